>>> design/sst_pkg.sv
// shared types, codes and saturating arithmetic for the sorted sample table
// no dependencies; imported by every module of the block
`default_nettype none

package sst_pkg;

    // operation codes of an input beat
    localparam logic [2:0] MODE_UPSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SET    = 3'd2;
    localparam logic [2:0] MODE_ADD    = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // duplicate policy codes
    localparam logic [2:0] POL_BLOCK = 3'd0;
    localparam logic [2:0] POL_FIRST = 3'd1;
    localparam logic [2:0] POL_LAST  = 3'd2;
    localparam logic [2:0] POL_MAX   = 3'd3;
    localparam logic [2:0] POL_MIN   = 3'd4;
    localparam logic [2:0] POL_SUM   = 3'd5;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_SKIPPED   = 3'd2;
    localparam logic [2:0] ST_BLOCKED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [63:0]        stamp;
        logic [63:0]        stamp_end;
        logic               include_end;
        logic signed [63:0] sample_value;
        logic [7:0]         latest_index;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [63:0]        result_stamp;
        logic signed [63:0] result_value;
        logic [8:0]         removed_count;
        logic [8:0]         entry_count;
    } t_out;

    // one table slot
    typedef struct packed {
        logic               valid;
        logic [63:0]        stamp;
        logic signed [63:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        CO_HOLD = 2'd0,
        CO_INS  = 2'd1,
        CO_DEL  = 2'd2,
        CO_WR   = 2'd3
    } t_cell_op;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic               by_idx;
        logic               tgt_ok;
        logic [63:0]        key;
        logic [63:0]        key_end;
        logic               incl;
        logic signed [63:0] wr_value;
    } t_cell_cmd;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? VAL_MIN : VAL_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? VAL_MIN : VAL_MAX;
        end
        return s[63:0];
    endfunction

endpackage

`default_nettype wire

>>> design/sst_cell.sv
// one slot of the sorted table: holds a sample, shifts to or from its neighbors,
// and passes a probe beat along the chain; uses sst_pkg
`default_nettype none

module sst_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sst_pkg::t_cell_cmd i_cmd,
    input  wire logic [IDX_W-1:0]   i_tgt,
    input  wire sst_pkg::t_entry    i_left,
    input  wire sst_pkg::t_entry    i_right,
    input  wire logic               i_prev_lt,
    input  wire sst_pkg::t_entry    i_probe,
    output sst_pkg::t_entry         o_ent,
    output logic                    o_lt,
    output logic                    o_in_range,
    output sst_pkg::t_entry         o_probe
);
    import sst_pkg::*;

    t_entry r_ent, n_ent;
    t_entry r_probe;
    logic   w_eq, w_ge, w_end_ok, w_hit;

    always_comb begin
        w_eq       = r_ent.valid && (r_ent.stamp == i_cmd.key);
        o_lt       = r_ent.valid && (r_ent.stamp < i_cmd.key);
        w_ge       = r_ent.valid && !(r_ent.stamp < i_cmd.key);
        w_end_ok   = i_cmd.incl ? (r_ent.stamp <= i_cmd.key_end)
                                : (r_ent.stamp < i_cmd.key_end);
        o_in_range = w_ge && w_end_ok;
        w_hit      = i_cmd.by_idx ? (r_ent.valid && i_cmd.tgt_ok &&
                                     (i_tgt == IDX_W'(CELL_IDX)))
                                  : w_eq;
    end

    always_comb begin
        n_ent = r_ent;
        case (i_cmd.op)
            CO_INS: begin
                // cells past the insert point take the left neighbor
                if (!i_prev_lt) begin
                    n_ent = i_left;
                end else if (!o_lt) begin
                    n_ent = '{valid: 1'b1, stamp: i_cmd.key, value: i_cmd.wr_value};
                end
            end
            CO_DEL: begin
                if (w_ge) begin
                    n_ent = i_right;
                end
            end
            CO_WR: begin
                if (w_eq) begin
                    n_ent.value = i_cmd.wr_value;
                end
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent.stamp <= n_ent.stamp;
        r_ent.value <= n_ent.value;
        r_probe     <= w_hit ? r_ent : i_probe;
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
    end

    assign o_ent   = r_ent;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

>>> design/sorted_sample_table_upsert_top.sv
// sorted sample table top level: sequencer plus a chain of sst_cell slots
// depends on sst_pkg and sst_cell
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------
//  command  | start / busy               | i_in  (sst_pkg::t_in)
//  result   | o_done, one cycle          | o_out (sst_pkg::t_out)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (policy)
//
// an operation runs through scan, calc, delta, apply and response; a range remove
// deletes one sample per cycle in apply; the probe must walk the whole cell chain
// before a decision. reset empties the table (slot valid bits), sets policy to block.
// a result shows for one cycle and cannot be stalled; a new command may be given
// in the same cycle its predecessor's result shows.
`default_nettype none

module sorted_sample_table_upsert_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire sst_pkg::t_in i_in,
    output logic              o_done,
    output sst_pkg::t_out     o_out,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_data
);
    import sst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CALC  = 6'b000100,
        S_DELTA = 6'b001000,
        S_APPLY = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state              r_state;
    t_in                 r_in;
    logic [2:0]          r_policy;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_removed;
    logic [IDX_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_tgt;
    logic                r_tgt_ok;
    logic                r_found;
    logic signed [63:0]  r_old;
    logic [63:0]         r_pstamp;
    logic signed [63:0]  r_new;
    logic [2:0]          r_status;
    logic signed [63:0]  r_rv;
    logic [63:0]         r_rs;
    logic                r_done;
    t_out                r_out;

    t_cell_cmd           w_cmd;
    t_entry              w_ent   [TABLE_DEPTH];
    t_entry              w_probe [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_lt;
    logic [TABLE_DEPTH-1:0] w_rng;
    logic                w_any_rng;
    logic                w_full;
    logic [CW+7:0]       w_lidx_x, w_cnt_x;
    t_entry              w_res;
    logic signed [63:0]  w_nv;
    logic [2:0]          w_st;
    logic signed [63:0]  w_rv;
    logic [63:0]         w_rs;

    assign w_any_rng = |w_rng;
    assign w_full    = (r_count == CW'(TABLE_DEPTH));
    assign w_lidx_x  = (CW + 8)'(i_in.latest_index);
    assign w_cnt_x   = (CW + 8)'(r_count);
    assign w_res     = w_probe[TABLE_DEPTH-1];

    // cell command
    always_comb begin
        w_cmd.op       = CO_HOLD;
        w_cmd.by_idx   = (r_in.mode == MODE_READ);
        w_cmd.tgt_ok   = r_tgt_ok;
        w_cmd.key      = r_in.stamp;
        w_cmd.key_end  = r_in.stamp_end;
        w_cmd.incl     = r_in.include_end;
        w_cmd.wr_value = r_found ? r_new : r_in.sample_value;
        if (r_state == S_APPLY) begin
            case (r_in.mode)
                MODE_UPSERT: begin
                    if (r_found) begin
                        w_cmd.op = CO_WR;
                    end else if (!w_full) begin
                        w_cmd.op = CO_INS;
                    end
                end
                MODE_REMOVE: begin
                    if (w_any_rng) begin
                        w_cmd.op = CO_DEL;
                    end
                end
                MODE_SET, MODE_ADD: begin
                    if (r_found) begin
                        w_cmd.op = CO_WR;
                    end
                end
                default: begin
                    w_cmd.op = CO_HOLD;
                end
            endcase
        end
    end

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        t_entry w_l, w_r, w_pin;
        logic   w_plt;
        if (gi == 0) begin : g_head
            assign w_l   = '0;
            assign w_pin = '0;
            assign w_plt = 1'b1;
        end else begin : g_body
            assign w_l   = w_ent[gi-1];
            assign w_pin = w_probe[gi-1];
            assign w_plt = w_lt[gi-1];
        end
        if (gi == TABLE_DEPTH - 1) begin : g_tail
            assign w_r = '0;
        end else begin : g_mid
            assign w_r = w_ent[gi+1];
        end
        sst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_tgt      (r_tgt),
            .i_left     (w_l),
            .i_right    (w_r),
            .i_prev_lt  (w_plt),
            .i_probe    (w_pin),
            .o_ent      (w_ent[gi]),
            .o_lt       (w_lt[gi]),
            .o_in_range (w_rng[gi]),
            .o_probe    (w_probe[gi])
        );
    end

    // new value and status once the probe has reached the chain end
    always_comb begin
        w_nv = w_res.value;
        w_st = ST_NOT_FOUND;
        case (r_in.mode)
            MODE_UPSERT: begin
                if (!w_res.valid) begin
                    w_st = w_full ? ST_FULL : ST_INSERTED;
                end else begin
                    case (r_policy)
                        POL_FIRST: w_st = ST_SKIPPED;
                        POL_LAST: begin
                            w_nv = r_in.sample_value;
                            w_st = (r_in.sample_value == w_res.value) ? ST_SKIPPED
                                                                       : ST_UPDATED;
                        end
                        POL_MAX: begin
                            if (r_in.sample_value > w_res.value) begin
                                w_nv = r_in.sample_value;
                                w_st = ST_UPDATED;
                            end else begin
                                w_st = ST_SKIPPED;
                            end
                        end
                        POL_MIN: begin
                            if (r_in.sample_value < w_res.value) begin
                                w_nv = r_in.sample_value;
                                w_st = ST_UPDATED;
                            end else begin
                                w_st = ST_SKIPPED;
                            end
                        end
                        POL_SUM: begin
                            w_nv = sat_add(w_res.value, r_in.sample_value);
                            w_st = (r_in.sample_value == 64'sd0) ? ST_SKIPPED : ST_UPDATED;
                        end
                        default: w_st = ST_BLOCKED;
                    endcase
                end
            end
            MODE_REMOVE: w_st = ST_DONE;
            MODE_SET: begin
                w_nv = r_in.sample_value;
                if (w_res.valid) begin
                    w_st = ST_UPDATED;
                end
            end
            MODE_ADD: begin
                w_nv = sat_add(w_res.value, r_in.sample_value);
                if (w_res.valid) begin
                    w_st = ST_UPDATED;
                end
            end
            MODE_READ: begin
                if (w_res.valid) begin
                    w_st = ST_DONE;
                end
            end
            default: w_st = ST_NOT_FOUND;
        endcase
    end

    // result value and stamp from the captured probe
    always_comb begin
        w_rv = 64'sd0;
        w_rs = r_in.stamp;
        case (r_in.mode)
            MODE_UPSERT: begin
                if (r_found) begin
                    w_rv = sat_sub(r_new, r_old);
                end else if (!w_full) begin
                    w_rv = r_in.sample_value;
                end
            end
            MODE_SET, MODE_ADD: begin
                if (r_found) begin
                    w_rv = r_new;
                end
            end
            MODE_READ: begin
                w_rs = r_found ? r_pstamp : 64'd0;
                if (r_found) begin
                    w_rv = r_old;
                end
            end
            MODE_REMOVE: w_rv = 64'sd0;
            default: w_rs = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= POL_BLOCK;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (r_state == S_RESP);
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in      <= i_in;
                        r_cnt     <= '0;
                        r_removed <= '0;
                        r_tgt_ok  <= w_lidx_x < w_cnt_x;
                        r_tgt     <= IDX_W'(w_cnt_x - (CW + 8)'(1) - w_lidx_x);
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_found  <= w_res.valid;
                    r_old    <= w_res.value;
                    r_pstamp <= w_res.stamp;
                    r_new    <= w_nv;
                    r_status <= w_st;
                    r_state  <= S_DELTA;
                end
                S_DELTA: begin
                    r_rv    <= w_rv;
                    r_rs    <= w_rs;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_cmd.op == CO_INS) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (w_cmd.op == CO_DEL) begin
                        // one sample leaves the chain per cycle
                        r_count   <= r_count - CW'(1);
                        r_removed <= r_removed + CW'(1);
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP) begin
            r_out.status        <= r_status;
            r_out.result_stamp  <= r_rs;
            r_out.result_value  <= r_rv;
            r_out.removed_count <= 9'(r_removed);
            r_out.entry_count   <= 9'(r_count);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> design/sst_chk.sv
// port-level checks on the sorted sample table top level, with its bind
// depends on sst_pkg and sorted_sample_table_upsert_top
`default_nettype none

module sst_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire sst_pkg::t_out o_out,
    input wire logic          o_cfg_ready
);
    import sst_pkg::*;

    // an accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && o_cfg_ready)
        else $error("result shown while still busy");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.status == ST_FULL) |-> (o_out.result_value == 64'sd0))
        else $error("table full result with nonzero value");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.status == ST_INSERTED) |-> (o_out.removed_count == 9'd0))
        else $error("insert reported removed samples");

endmodule

bind sorted_sample_table_upsert_top sst_chk u_sst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out       (o_out),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
